[rtl/assert_macros.svh]
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on aclk, off while aresetn is low.
`define VAHF_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("vahf assertion failed");

// Next-cycle implication, sampled on aclk, off while aresetn is low.
`define VAHF_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("vahf assertion failed");

`endif

[rtl/vahf_pkg.sv]
`default_nettype none

package vahf_pkg;

    // default frame and end-hold times, ms
    localparam int unsigned FRAME_TIME_MS_DEF    = 20;
    localparam int unsigned END_HOLD_TIME_MS_DEF = 800;

    localparam int unsigned TIMER_W   = 16;
    localparam int unsigned CFG_IDX_W = 4;
    localparam int unsigned CFG_DAT_W = 16;

    typedef enum logic [1:0] {
        MODE_IDLE     = 2'd0,
        MODE_SPEAKING = 2'd1,
        MODE_HOLD     = 2'd2
    } vahf_mode_t;

    typedef enum logic [1:0] {
        EV_NONE  = 2'd0,
        EV_START = 2'd1,
        EV_END   = 2'd2
    } vahf_event_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_ADC_RMS_START = 4'd0,
        REG_ADC_P2P_START = 4'd1,
        REG_PCM_RMS_START = 4'd2,
        REG_PCM_P2P_START = 4'd3,
        REG_ADC_RMS_STOP  = 4'd4,
        REG_ADC_P2P_STOP  = 4'd5,
        REG_PCM_RMS_STOP  = 4'd6,
        REG_PCM_P2P_STOP  = 4'd7
    } vahf_reg_idx_t;

    typedef struct packed {
        logic [12:0] clip_count;
        logic [11:0] raw_rms;
        logic [11:0] raw_peak_to_peak;
        logic [14:0] audio_rms;
        logic [15:0] audio_peak_to_peak;
    } vahf_stats_t;

    typedef struct packed {
        logic [11:0] adc_rms_start;
        logic [11:0] adc_p2p_start;
        logic [14:0] pcm_rms_start;
        logic [15:0] pcm_p2p_start;
        logic [11:0] adc_rms_stop;
        logic [11:0] adc_p2p_stop;
        logic [14:0] pcm_rms_stop;
        logic [15:0] pcm_p2p_stop;
    } vahf_thr_t;

    typedef struct packed {
        logic active;
        logic quiet;
    } vahf_flags_t;

    localparam vahf_thr_t THR_RESET = '{
        adc_rms_start: 12'd200,
        adc_p2p_start: 12'd800,
        pcm_rms_start: 15'd1000,
        pcm_p2p_start: 16'd4000,
        adc_rms_stop:  12'd100,
        adc_p2p_stop:  12'd400,
        pcm_rms_stop:  15'd500,
        pcm_p2p_stop:  16'd2000
    };

endpackage

`default_nettype wire

[rtl/vahf_classify.sv]
`default_nettype none

// Frame classifier: active if anything clipped or any stat hits its start
// level; quiet if nothing clipped and every stat is at/below its stop level.
module vahf_classify (
    input  wire vahf_pkg::vahf_stats_t stats,
    input  wire vahf_pkg::vahf_thr_t   thr,
    output vahf_pkg::vahf_flags_t      flags
);

    logic clipped;

    assign clipped = (stats.clip_count != '0);

    assign flags.active = clipped
                       || (stats.raw_rms            >= thr.adc_rms_start)
                       || (stats.raw_peak_to_peak   >= thr.adc_p2p_start)
                       || (stats.audio_rms          >= thr.pcm_rms_start)
                       || (stats.audio_peak_to_peak >= thr.pcm_p2p_start);

    assign flags.quiet = !clipped
                      && (stats.raw_rms            <= thr.adc_rms_stop)
                      && (stats.raw_peak_to_peak   <= thr.adc_p2p_stop)
                      && (stats.audio_rms          <= thr.pcm_rms_stop)
                      && (stats.audio_peak_to_peak <= thr.pcm_p2p_stop);

endmodule

`default_nettype wire

[rtl/voice_activity_hysteresis_fsm_core.sv]
`default_nettype none

// Voice activity detector with hysteresis. Each input word carries one
// frame's statistics (clip count, raw ADC RMS and peak-to-peak, PCM RMS and
// peak-to-peak) and yields exactly one result word with m_event_res:
// 0 none, 1 voice start (idle -> speaking), 2 voice end (silence hold has
// lasted END_HOLD_TIME_MS, counted in steps of FRAME_TIME_MS per quiet
// frame). One word per cycle is taken when m_ready does not stall; words
// pass the input register, then the result register (classifier and state
// update between), and a new word is taken while a finished result still
// waits on m_ready. The eight thresholds are written through the cfg port
// (index 0..7, other indexes are ignored, data masked to the register
// width); the user must do so only while the block is idle, which it does not enforce.
module voice_activity_hysteresis_fsm_core #(
    parameter int unsigned FRAME_TIME_MS    = vahf_pkg::FRAME_TIME_MS_DEF,
    parameter int unsigned END_HOLD_TIME_MS = vahf_pkg::END_HOLD_TIME_MS_DEF
) (
    input  wire logic                             aclk,
    input  wire logic                             aresetn,

    // frame statistics in
    input  wire logic                             s_valid,
    output logic                                  s_ready,
    input  wire logic [12:0]                      s_clip_count,
    input  wire logic [11:0]                      s_raw_rms,
    input  wire logic [11:0]                      s_raw_peak_to_peak,
    input  wire logic [14:0]                      s_audio_rms,
    input  wire logic [15:0]                      s_audio_peak_to_peak,

    // event out
    output logic                                  m_valid,
    input  wire logic                             m_ready,
    output logic [1:0]                            m_event_res,

    // threshold writes
    input  wire logic                             cfg_valid,
    output logic                                  cfg_ready,
    input  wire logic [vahf_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  wire logic [vahf_pkg::CFG_DAT_W-1:0]   cfg_data
);

    localparam int unsigned TW = vahf_pkg::TIMER_W;
    localparam logic [TW-1:0] FRAME_STEP = TW'(FRAME_TIME_MS);
    localparam logic [TW-1:0] END_HOLD   = TW'(END_HOLD_TIME_MS);

    // ---------------- threshold registers ----------------
    vahf_pkg::vahf_thr_t thr_reg;

    assign cfg_ready = 1'b1;   // writes are always accepted

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            thr_reg <= vahf_pkg::THR_RESET;
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_index)
                vahf_pkg::REG_ADC_RMS_START: thr_reg.adc_rms_start <= cfg_data[11:0];
                vahf_pkg::REG_ADC_P2P_START: thr_reg.adc_p2p_start <= cfg_data[11:0];
                vahf_pkg::REG_PCM_RMS_START: thr_reg.pcm_rms_start <= cfg_data[14:0];
                vahf_pkg::REG_PCM_P2P_START: thr_reg.pcm_p2p_start <= cfg_data[15:0];
                vahf_pkg::REG_ADC_RMS_STOP:  thr_reg.adc_rms_stop  <= cfg_data[11:0];
                vahf_pkg::REG_ADC_P2P_STOP:  thr_reg.adc_p2p_stop  <= cfg_data[11:0];
                vahf_pkg::REG_PCM_RMS_STOP:  thr_reg.pcm_rms_stop  <= cfg_data[14:0];
                vahf_pkg::REG_PCM_P2P_STOP:  thr_reg.pcm_p2p_stop  <= cfg_data[15:0];
                default: ;  // out-of-range index: dropped
            endcase
        end
    end

    // ---------------- input register ----------------
    logic                  in_valid_reg;
    vahf_pkg::vahf_stats_t stats_reg;
    logic                  move;   // input stage hands its word to the result stage

    assign move    = in_valid_reg && (!m_valid || m_ready);
    assign s_ready = !in_valid_reg || move;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            stats_reg.clip_count         <= s_clip_count;
            stats_reg.raw_rms            <= s_raw_rms;
            stats_reg.raw_peak_to_peak   <= s_raw_peak_to_peak;
            stats_reg.audio_rms          <= s_audio_rms;
            stats_reg.audio_peak_to_peak <= s_audio_peak_to_peak;
        end
    end

    // ---------------- classify ----------------
    vahf_pkg::vahf_flags_t flags;

    vahf_classify u_classify (
        .stats (stats_reg),
        .thr   (thr_reg),
        .flags (flags)
    );

    // ---------------- detector state ----------------
    vahf_pkg::vahf_mode_t  mode_reg, mode_next;
    logic [TW-1:0]         silence_reg, silence_next;
    vahf_pkg::vahf_event_t ev_next;
    logic [TW:0]           silence_sum;
    logic [TW-1:0]         silence_inc;   // saturating silence + frame step
    logic                  hold_quiet;    // quiet frame in silence hold
    logic                  hold_done;

    assign silence_sum = {1'b0, silence_reg} + {1'b0, FRAME_STEP};
    assign silence_inc = silence_sum[TW] ? '1 : silence_sum[TW-1:0];
    assign hold_quiet  = !flags.active && flags.quiet;
    assign hold_done   = (silence_inc >= END_HOLD);

    // next state and timer
    always_comb begin
        mode_next    = mode_reg;
        silence_next = silence_reg;
        unique case (mode_reg)
            vahf_pkg::MODE_IDLE: begin
                if (flags.active) begin
                    mode_next    = vahf_pkg::MODE_SPEAKING;
                    silence_next = '0;
                end
            end
            vahf_pkg::MODE_SPEAKING: begin
                if (flags.quiet) begin
                    mode_next    = vahf_pkg::MODE_HOLD;
                    silence_next = FRAME_STEP;   // first quiet frame counts
                end else begin
                    silence_next = '0;
                end
            end
            vahf_pkg::MODE_HOLD: begin
                if (hold_quiet && hold_done) begin
                    mode_next    = vahf_pkg::MODE_IDLE;
                    silence_next = '0;
                end else if (hold_quiet) begin
                    silence_next = silence_inc;
                end else begin
                    // speech came back before the hold ran out
                    mode_next    = vahf_pkg::MODE_SPEAKING;
                    silence_next = '0;
                end
            end
            default: begin
                // illegal encoding: recover to idle silently
                mode_next    = vahf_pkg::MODE_IDLE;
                silence_next = '0;
            end
        endcase
    end

    // event out of the current word
    always_comb begin
        ev_next = vahf_pkg::EV_NONE;
        unique case (mode_reg)
            vahf_pkg::MODE_IDLE:     if (flags.active) ev_next = vahf_pkg::EV_START;
            vahf_pkg::MODE_SPEAKING: ev_next = vahf_pkg::EV_NONE;
            vahf_pkg::MODE_HOLD:     if (hold_quiet && hold_done) ev_next = vahf_pkg::EV_END;
            default:                 ev_next = vahf_pkg::EV_NONE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg    <= vahf_pkg::MODE_IDLE;
            silence_reg <= '0;
        end else if (move) begin
            mode_reg    <= mode_next;
            silence_reg <= silence_next;
        end
    end

    // ---------------- result register ----------------
    vahf_pkg::vahf_event_t event_reg;
    logic                  out_valid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (move) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (move) begin
            event_reg <= ev_next;
        end
    end

    assign m_valid     = out_valid_reg;
    assign m_event_res = event_reg;

    // ---------------- assertions ----------------
`include "assert_macros.svh"

    // idle always carries a cleared timer
    `VAHF_ASSERT_NOW(a_idle_timer_clear, mode_reg == vahf_pkg::MODE_IDLE, silence_reg == '0)
    // silence hold has counted at least the entering frame
    `VAHF_ASSERT_NOW(a_hold_timer_min, mode_reg == vahf_pkg::MODE_HOLD, silence_reg >= FRAME_STEP)
    // voice start leaves the machine speaking with a clear timer
    `VAHF_ASSERT_NEXT(a_start_to_speaking, move && ev_next == vahf_pkg::EV_START,
        mode_reg == vahf_pkg::MODE_SPEAKING && silence_reg == '0)
    // voice end leaves the machine idle
    `VAHF_ASSERT_NEXT(a_end_to_idle, move && ev_next == vahf_pkg::EV_END,
        mode_reg == vahf_pkg::MODE_IDLE && m_valid)
    // a word in the input stage blocked by a full result stage stays put
    `VAHF_ASSERT_NEXT(a_stage_hold, in_valid_reg && !move, in_valid_reg && $stable(stats_reg))

endmodule

`default_nettype wire

[tb/tb_voice_activity_hysteresis_fsm_core.sv]
`timescale 1ns / 1ps

module tb_voice_activity_hysteresis_fsm_core;

    import vahf_pkg::*;

    localparam int unsigned FRAME_MS    = FRAME_TIME_MS_DEF;
    localparam int unsigned END_MS      = END_HOLD_TIME_MS_DEF;
    // quiet frames (entry frame included) needed to reach the end-hold time
    localparam int unsigned HOLD_FRAMES = (END_MS + FRAME_MS - 1) / FRAME_MS;
    localparam int unsigned TIMER_MAX   = (1 << TIMER_W) - 1;
    localparam int unsigned CLIP_MAX    = 4096;
    // slack left after the last event drains
    localparam int unsigned SETTLE_CYCLES = 6;
    localparam int unsigned CYCLE_LIMIT   = 400000;

    // indexes outside the register file, writes must be dropped
    localparam logic [CFG_IDX_W-1:0] REG_IDX_SPARE_LO = 4'd8;
    localparam logic [CFG_IDX_W-1:0] REG_IDX_SPARE_HI = 4'd15;

    logic        aclk    = 1'b0;
    logic        aresetn = 1'b0;

    logic        s_valid              = 1'b0;
    logic        s_ready;
    logic [12:0] s_clip_count         = '0;
    logic [11:0] s_raw_rms            = '0;
    logic [11:0] s_raw_peak_to_peak   = '0;
    logic [14:0] s_audio_rms          = '0;
    logic [15:0] s_audio_peak_to_peak = '0;

    logic        m_valid;
    logic        m_ready = 1'b0;
    logic [1:0]  m_event_res;

    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [CFG_DAT_W-1:0] cfg_data  = '0;

    voice_activity_hysteresis_fsm_core #(
        .FRAME_TIME_MS   (FRAME_MS),
        .END_HOLD_TIME_MS(END_MS)
    ) uut (
        .aclk                (aclk),
        .aresetn             (aresetn),
        .s_valid             (s_valid),
        .s_ready             (s_ready),
        .s_clip_count        (s_clip_count),
        .s_raw_rms           (s_raw_rms),
        .s_raw_peak_to_peak  (s_raw_peak_to_peak),
        .s_audio_rms         (s_audio_rms),
        .s_audio_peak_to_peak(s_audio_peak_to_peak),
        .m_valid             (m_valid),
        .m_ready             (m_ready),
        .m_event_res         (m_event_res),
        .cfg_valid           (cfg_valid),
        .cfg_ready           (cfg_ready),
        .cfg_index           (cfg_index),
        .cfg_data            (cfg_data)
    );

    // Detector shadow: thresholds, mode and silence timer, updated when a
    // word or a register write is accepted.
    vahf_thr_t   thr_model  = THR_RESET;
    vahf_mode_t  mode_model = MODE_IDLE;
    int unsigned hold_ms    = 0;

    vahf_event_t event_fifo[$];   // expected events, oldest first
    vahf_event_t event_due;

    int unsigned snd_gap_pct   = 0;   // chance per cycle that the sender holds off
    int unsigned rcv_stall_pct = 0;   // chance per cycle that m_ready is low
    int unsigned words_sent    = 0;
    int unsigned events_seen   = 0;
    int unsigned err_count     = 0;
    int unsigned cycle_cnt     = 0;

    initial begin
        forever #10 aclk = ~aclk;
    end

    // Watchdog: a hung handshake ends the run as a failure.
    always @(posedge aclk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt >= CYCLE_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end
    end

    task automatic report_mismatch(input string what, input logic [1:0] got,
                                   input logic [1:0] want);
        $display("ERROR event word %0d: %s, got %0d want %0d",
                 events_seen, what, got, want);
        err_count++;
    endtask

    // Classify the frame against the shadow thresholds and step the
    // hysteresis machine; returns the event the block must emit.
    function automatic vahf_event_t predict_event(input vahf_stats_t f);
        logic        loud;
        logic        hushed;
        vahf_event_t ev;
        loud = (f.clip_count != 0) ||
               (f.raw_rms >= thr_model.adc_rms_start) ||
               (f.raw_peak_to_peak >= thr_model.adc_p2p_start) ||
               (f.audio_rms >= thr_model.pcm_rms_start) ||
               (f.audio_peak_to_peak >= thr_model.pcm_p2p_start);
        hushed = (f.clip_count == 0) &&
                 (f.raw_rms <= thr_model.adc_rms_stop) &&
                 (f.raw_peak_to_peak <= thr_model.adc_p2p_stop) &&
                 (f.audio_rms <= thr_model.pcm_rms_stop) &&
                 (f.audio_peak_to_peak <= thr_model.pcm_p2p_stop);
        ev = EV_NONE;
        case (mode_model)
            MODE_IDLE: begin
                if (loud) begin
                    mode_model = MODE_SPEAKING;
                    hold_ms    = 0;
                    ev         = EV_START;
                end
            end
            MODE_SPEAKING: begin
                // entering hold loads one frame; no end test on this frame
                if (hushed) begin
                    mode_model = MODE_HOLD;
                    hold_ms    = (FRAME_MS > TIMER_MAX) ? TIMER_MAX : FRAME_MS;
                end else begin
                    hold_ms = 0;
                end
            end
            MODE_HOLD: begin
                if (!loud && hushed) begin
                    hold_ms = (hold_ms + FRAME_MS > TIMER_MAX) ? TIMER_MAX
                                                               : hold_ms + FRAME_MS;
                    if (hold_ms >= END_MS) begin
                        mode_model = MODE_IDLE;
                        hold_ms    = 0;
                        ev         = EV_END;
                    end
                end else begin
                    // any non-quiet frame (even active and quiet at once) resumes speech
                    mode_model = MODE_SPEAKING;
                    hold_ms    = 0;
                end
            end
            default: begin
                mode_model = MODE_IDLE;
                hold_ms    = 0;
            end
        endcase
        return ev;
    endfunction

    // Send one frame word. Valid is only dropped during a gap, so back to
    // back words keep valid high without a second assignment in one step.
    task automatic send_word(input vahf_stats_t f);
        while ($urandom_range(99, 0) < snd_gap_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid              <= 1'b1;
        s_clip_count         <= f.clip_count;
        s_raw_rms            <= f.raw_rms;
        s_raw_peak_to_peak   <= f.raw_peak_to_peak;
        s_audio_rms          <= f.audio_rms;
        s_audio_peak_to_peak <= f.audio_peak_to_peak;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        event_fifo.push_back(predict_event(f));
        words_sent++;
    endtask

    // Result side: random back-pressure, compare each event in order.
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                if (event_fifo.size() == 0) begin
                    report_mismatch("event with none outstanding", m_event_res, EV_NONE);
                end else begin
                    event_due = event_fifo.pop_front();
                    if (m_event_res !== event_due)
                        report_mismatch("event_res", m_event_res, event_due);
                end
                events_seen++;
            end
            m_ready <= ($urandom_range(99, 0) >= rcv_stall_pct);
        end
    end

    // Stop sending and let every outstanding event drain.
    task automatic wait_quiet();
        s_valid <= 1'b0;
        while (event_fifo.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    // Caller lowers cfg_valid after the last write of a batch.
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DAT_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        case (idx)
            REG_ADC_RMS_START: thr_model.adc_rms_start = data[11:0];
            REG_ADC_P2P_START: thr_model.adc_p2p_start = data[11:0];
            REG_PCM_RMS_START: thr_model.pcm_rms_start = data[14:0];
            REG_PCM_P2P_START: thr_model.pcm_p2p_start = data[15:0];
            REG_ADC_RMS_STOP:  thr_model.adc_rms_stop  = data[11:0];
            REG_ADC_P2P_STOP:  thr_model.adc_p2p_stop  = data[11:0];
            REG_PCM_RMS_STOP:  thr_model.pcm_rms_stop  = data[14:0];
            REG_PCM_P2P_STOP:  thr_model.pcm_p2p_stop  = data[15:0];
            default: ;
        endcase
    endtask

    // Junk in the bits above each register width checks the masking;
    // the spare indexes must leave the thresholds alone.
    task automatic load_thresholds(input vahf_thr_t t);
        wait_quiet();
        write_reg(REG_ADC_RMS_START, {4'($urandom), t.adc_rms_start});
        write_reg(REG_IDX_SPARE_LO,  16'($urandom));
        write_reg(REG_ADC_P2P_START, {4'($urandom), t.adc_p2p_start});
        write_reg(REG_PCM_RMS_START, {1'($urandom), t.pcm_rms_start});
        write_reg(REG_PCM_P2P_START, t.pcm_p2p_start);
        write_reg(REG_ADC_RMS_STOP,  {4'($urandom), t.adc_rms_stop});
        write_reg(REG_ADC_P2P_STOP,  {4'($urandom), t.adc_p2p_stop});
        write_reg(REG_PCM_RMS_STOP,  {1'($urandom), t.pcm_rms_stop});
        write_reg(REG_PCM_P2P_STOP,  t.pcm_p2p_stop);
        write_reg(REG_IDX_SPARE_HI,  16'($urandom));
        cfg_valid <= 1'b0;
    endtask

    function automatic vahf_stats_t frame_of(input int c, input int rr, input int rp,
                                             input int ar, input int ap);
        vahf_stats_t f;
        f.clip_count         = 13'(c);
        f.raw_rms            = 12'(rr);
        f.raw_peak_to_peak   = 12'(rp);
        f.audio_rms          = 15'(ar);
        f.audio_peak_to_peak = 16'(ap);
        return f;
    endfunction

    function automatic vahf_stats_t make_noise();
        vahf_stats_t f;
        f.clip_count         = $urandom_range(1, 0) ? 13'd0 : 13'($urandom_range(CLIP_MAX, 0));
        f.raw_rms            = 12'($urandom);
        f.raw_peak_to_peak   = 12'($urandom);
        f.audio_rms          = 15'($urandom);
        f.audio_peak_to_peak = 16'($urandom);
        return f;
    endfunction

    // at least one trigger at or over its start level, the rest anything
    function automatic vahf_stats_t make_active();
        vahf_stats_t f;
        f = make_noise();
        case ($urandom_range(4, 0))
            0: f.clip_count = 13'($urandom_range(CLIP_MAX, 1));
            1: f.raw_rms = 12'($urandom_range(12'hFFF, thr_model.adc_rms_start));
            2: f.raw_peak_to_peak = 12'($urandom_range(12'hFFF, thr_model.adc_p2p_start));
            3: f.audio_rms = 15'($urandom_range(15'h7FFF, thr_model.pcm_rms_start));
            default: f.audio_peak_to_peak =
                         16'($urandom_range(16'hFFFF, thr_model.pcm_p2p_start));
        endcase
        return f;
    endfunction

    function automatic vahf_stats_t make_quiet();
        vahf_stats_t f;
        f.clip_count         = '0;
        f.raw_rms            = 12'($urandom_range(thr_model.adc_rms_stop, 0));
        f.raw_peak_to_peak   = 12'($urandom_range(thr_model.adc_p2p_stop, 0));
        f.audio_rms          = 15'($urandom_range(thr_model.pcm_rms_stop, 0));
        f.audio_peak_to_peak = 16'($urandom_range(thr_model.pcm_p2p_stop, 0));
        return f;
    endfunction

    // below every start level: lands in the dead band or is quiet
    function automatic vahf_stats_t make_between();
        vahf_stats_t f;
        f.clip_count = '0;
        f.raw_rms = (thr_model.adc_rms_start == 0) ? '0
                    : 12'($urandom_range(thr_model.adc_rms_start - 1, 0));
        f.raw_peak_to_peak = (thr_model.adc_p2p_start == 0) ? '0
                    : 12'($urandom_range(thr_model.adc_p2p_start - 1, 0));
        f.audio_rms = (thr_model.pcm_rms_start == 0) ? '0
                    : 15'($urandom_range(thr_model.pcm_rms_start - 1, 0));
        f.audio_peak_to_peak = (thr_model.pcm_p2p_start == 0) ? '0
                    : 16'($urandom_range(thr_model.pcm_p2p_start - 1, 0));
        return f;
    endfunction

    // Hand-picked frames against the reset thresholds
    // (start 200/800/1000/4000, stop 100/400/500/2000).
    task automatic test_directed_frames();
        send_word(frame_of(0, 0, 0, 0, 0));               // idle, quiet: nothing
        send_word(frame_of(0, 199, 799, 999, 3999));      // just under every start
        send_word(frame_of(0, 200, 0, 0, 0));             // start level exactly: voice start
        send_word(frame_of(0, 100, 400, 500, 2000));      // stop level exactly: into hold
        send_word(frame_of(0, 101, 0, 0, 0));             // dead band in hold: back to speech
        send_word(frame_of(0, 0, 401, 0, 0));             // dead band while speaking
        send_word(frame_of(0, 0, 0, 0, 0));               // into hold
        send_word(frame_of(1, 0, 0, 0, 0));               // one clipped sample ends the hold
        send_word(frame_of(0, 0, 0, 0, 2000));            // into hold
        send_word(frame_of(0, 0, 0, 1000, 0));            // PCM RMS start in hold
        send_word(frame_of(0, 0, 0, 0, 4000));            // active while speaking: no event
        send_word(frame_of(0, 0, 0, 0, 0));               // into hold
        // full hold; the last frame reaches the end-hold time
        repeat (HOLD_FRAMES - 1) send_word(frame_of(0, 100, 400, 500, 2000));
        send_word(frame_of(0, 0, 0, 0, 0));               // idle stays idle
        send_word(frame_of(CLIP_MAX, 4095, 4095, 32767, 65535));   // all at max
        send_word(frame_of(0, 0, 0, 0, 0));               // into hold
        send_word(frame_of(0, 0, 800, 0, 0));             // raw p2p start in hold
        send_word(frame_of(0, 0, 0, 0, 0));               // into hold
        repeat (HOLD_FRAMES - 2) send_word(frame_of(0, 0, 0, 0, 0));
        send_word(frame_of(0, 4095, 0, 0, 0));            // one frame short of the end
        send_word(frame_of(0, 0, 0, 0, 0));               // back into hold
        repeat (HOLD_FRAMES - 1) send_word(frame_of(0, 0, 0, 0, 0));
        send_word(frame_of(CLIP_MAX, 0, 0, 0, 0));        // clip alone starts voice
    endtask

    // Talk spurts: lead-in, speech, dead band, then a silence run that
    // either lasts out the hold or is cut short; some noise and broken
    // holds mixed in.
    task automatic test_talk_spurts(input int unsigned n_words);
        int unsigned stop_at;
        int unsigned run_len;
        stop_at = words_sent + n_words;
        while (words_sent < stop_at) begin
            repeat ($urandom_range(2, 0))
                send_word($urandom_range(1, 0) ? make_quiet() : make_between());
            repeat ($urandom_range(5, 1)) send_word(make_active());
            repeat ($urandom_range(3, 0))
                send_word($urandom_range(1, 0) ? make_between() : make_active());
            run_len = $urandom_range(1, 0) ? $urandom_range(HOLD_FRAMES + 5, HOLD_FRAMES - 1)
                                           : $urandom_range(HOLD_FRAMES - 2, 1);
            repeat (run_len) send_word(make_quiet());
            if ($urandom_range(3, 0) == 0) begin
                send_word($urandom_range(1, 0) ? make_active() : make_between());
                repeat ($urandom_range(5, 1)) send_word(make_quiet());
            end
            if ($urandom_range(6, 0) == 0)
                repeat ($urandom_range(4, 1)) send_word(make_noise());
        end
    endtask

    // Random thresholds with start above stop, so the dead band exists.
    task automatic test_threshold_config(input int unsigned n_words);
        vahf_thr_t t;
        t.adc_rms_stop  = 12'($urandom_range(2047, 0));
        t.adc_p2p_stop  = 12'($urandom_range(2047, 0));
        t.pcm_rms_stop  = 15'($urandom_range(16383, 0));
        t.pcm_p2p_stop  = 16'($urandom_range(32767, 0));
        t.adc_rms_start = 12'($urandom_range(4095, t.adc_rms_stop + 1));
        t.adc_p2p_start = 12'($urandom_range(4095, t.adc_p2p_stop + 1));
        t.pcm_rms_start = 15'($urandom_range(32767, t.pcm_rms_stop + 1));
        t.pcm_p2p_start = 16'($urandom_range(65535, t.pcm_p2p_stop + 1));
        load_thresholds(t);
        test_talk_spurts(n_words);
    endtask

    // Starts at zero with stops at max: every frame is active and most are
    // also quiet. Then the reverse: only max levels or clips are active and
    // only an all-zero frame is quiet.
    task automatic test_threshold_extremes();
        vahf_thr_t t;
        t = '0;
        t.adc_rms_stop = '1;
        t.adc_p2p_stop = '1;
        t.pcm_rms_stop = '1;
        t.pcm_p2p_stop = '1;
        load_thresholds(t);
        test_talk_spurts(60);
        t = '0;
        t.adc_rms_start = '1;
        t.adc_p2p_start = '1;
        t.pcm_rms_start = '1;
        t.pcm_p2p_start = '1;
        load_thresholds(t);
        test_talk_spurts(60);
    endtask

    initial begin
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;

        // sender mostly busy, receiver mostly stalled
        snd_gap_pct   = 12;
        rcv_stall_pct = 70;
        test_directed_frames();
        test_talk_spurts(200);

        // sender mostly idle, receiver mostly ready
        snd_gap_pct   = 70;
        rcv_stall_pct = 12;
        test_threshold_config(150);
        test_threshold_extremes();

        // full rate both ways
        snd_gap_pct   = 0;
        rcv_stall_pct = 0;
        test_threshold_config(150);

        wait_quiet();
        if (err_count == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule

[voice_activity_hysteresis_fsm_core.f]
+incdir+rtl
rtl/vahf_pkg.sv
rtl/vahf_classify.sv
rtl/voice_activity_hysteresis_fsm_core.sv
tb/tb_voice_activity_hysteresis_fsm_core.sv
